// File: hdl/c_string_escape_decoder_assert.svh
// ----------------------------------------------------------------------------
// C string escape decoder assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef C_STRING_ESCAPE_DECODER_ASSERT_SVH
`define C_STRING_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication
`define CSE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cse_pkg.sv
// ----------------------------------------------------------------------------
// C string escape decoder package
// Types, codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package cse_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_BODY    = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX     = 4'd3,
    PH_OCT     = 4'd4,
    PH_U4      = 4'd5,
    PH_U8      = 4'd6,
    PH_WANT_BS = 4'd7,
    PH_WANT_U  = 4'd8,
    PH_LOW4    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_OPENER    = 3'd0,
    ERR_UNIVERSAL    = 3'd1,
    ERR_SURROGATE    = 3'd2,
    ERR_RANGE        = 3'd3,
    ERR_UNTERMINATED = 3'd4
  } err_t;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_DELIMITER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_END = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNICODE   = 2'd2;

  localparam logic [7:0] DELIM_RST = 8'd34;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_7      = "7";
  localparam logic [7:0] CH_9      = "9";
  localparam logic [7:0] CH_LA     = "a";
  localparam logic [7:0] CH_LB     = "b";
  localparam logic [7:0] CH_LF     = "f";
  localparam logic [7:0] CH_LN     = "n";
  localparam logic [7:0] CH_LR     = "r";
  localparam logic [7:0] CH_LT     = "t";
  localparam logic [7:0] CH_LU     = "u";
  localparam logic [7:0] CH_LV     = "v";
  localparam logic [7:0] CH_LX     = "x";
  localparam logic [7:0] CH_UA     = "A";
  localparam logic [7:0] CH_UF     = "F";
  localparam logic [7:0] CH_UU     = "U";

  localparam logic [31:0] HI_SURR_MIN = 32'h0000_D800;
  localparam logic [31:0] HI_SURR_MAX = 32'h0000_DBFF;
  localparam logic [31:0] LO_SURR_MIN = 32'h0000_DC00;
  localparam logic [31:0] LO_SURR_MAX = 32'h0000_DFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h1_0000;
  localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
  } res_t;

  // one decoded request's results; n == 0 means nothing to queue
  typedef struct packed {
    logic [2:0]               n;
    res_t [MAX_RES-1:0]       r;
  } grp_t;

endpackage

// File: hdl/cse_in_if.sv
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready stream carrying one source byte per request.
// ----------------------------------------------------------------------------
interface cse_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hdl/cse_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready stream carrying one decoded result per request.
// ----------------------------------------------------------------------------
interface cse_out_if import cse_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] out_byte;
  err_t       error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

// File: hdl/cse_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write requests: register index and write data.
// ----------------------------------------------------------------------------
interface cse_cfg_if import cse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [7:0]            wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: hdl/cse_decode.sv
// ----------------------------------------------------------------------------
// C string escape decoder step logic
// Input register, config registers, parser state and one-pass decode of a
// registered byte into a group of up to four results.
// ----------------------------------------------------------------------------
`include "c_string_escape_decoder_assert.svh"

module cse_decode import cse_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  cse_in_if.sink       in_chan,
  cse_cfg_if.sink      cfg_chan,
  input  logic         q_ready,
  output grp_t         grp
);

  typedef struct packed {
    logic   vld;
    res_t   r;
    phase_t ph;
  } body_t;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        step;

  logic [7:0]  delim_r;
  logic        check_end_r;
  logic        unicode_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  grp_t        grp_step;
  body_t       bo;
  logic        hx_ok;
  logic [3:0]  hx_d;
  logic        is_oct;
  logic [31:0] uv;
  logic [31:0] oct_v;
  logic [3:0]  uc;
  logic [3:0]  need;

  function automatic res_t mk_data(input logic [7:0] b);
    mk_data = '{kind: KIND_DATA, data: b, err: ERR_NO_OPENER};
  endfunction

  function automatic res_t mk_err(input err_t e);
    mk_err = '{kind: KIND_ERROR, data: 8'h00, err: e};
  endfunction

  function automatic res_t mk_close();
    mk_close = '{kind: KIND_CLOSE, data: 8'h00, err: ERR_NO_OPENER};
  endfunction

  function automatic body_t body_step(input logic [7:0] b, input logic [7:0] dl,
                                      input logic chk);
    body_t o;
    o = '{vld: 1'b0, r: mk_data(b), ph: PH_BODY};
    if (b == dl) begin
      o.vld = 1'b1;
      o.r   = mk_close();
      o.ph  = PH_IDLE;
    end else if (b == CH_BSLASH) begin
      o.ph  = PH_ESC;
    end else if (b < CH_SPACE && b != CH_TAB) begin
      o.vld = 1'b1;
      if (chk) begin
        o.r  = mk_err(ERR_UNTERMINATED);
        o.ph = PH_IDLE;
      end else if (b == 8'h00) begin
        o.r  = mk_close();
        o.ph = PH_IDLE;
      end
    end else begin
      o.vld = 1'b1;
    end
    body_step = o;
  endfunction

  function automatic grp_t utf8(input logic [20:0] cp);
    grp_t g;
    g = '0;
    if (cp < 21'h80) begin
      g.n    = 3'd1;
      g.r[0] = mk_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      g.n    = 3'd2;
      g.r[0] = mk_data({3'b110, cp[10:6]});
      g.r[1] = mk_data({2'b10, cp[5:0]});
    end else if (cp < 21'h1_0000) begin
      g.n    = 3'd3;
      g.r[0] = mk_data({4'hE, cp[15:12]});
      g.r[1] = mk_data({2'b10, cp[11:6]});
      g.r[2] = mk_data({2'b10, cp[5:0]});
    end else begin
      g.n    = 3'd4;
      g.r[0] = mk_data({5'b11110, cp[20:18]});
      g.r[1] = mk_data({2'b10, cp[17:12]});
      g.r[2] = mk_data({2'b10, cp[11:6]});
      g.r[3] = mk_data({2'b10, cp[5:0]});
    end
    utf8 = g;
  endfunction

  assign step          = in_v_r && q_ready;
  assign in_chan.ready = !in_v_r || q_ready;
  assign cfg_chan.ready = 1'b1;
  assign grp           = step ? grp_step : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= DELIM_RST;
      check_end_r <= 1'b0;
      unicode_r   <= 1'b1;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.addr)
        REG_DELIMITER: delim_r     <= cfg_chan.wdata;
        REG_CHECK_END: check_end_r <= cfg_chan.wdata[0];
        REG_UNICODE:   unicode_r   <= cfg_chan.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      hs_r    <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      hs_r    <= hs_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    hs_nxt    = hs_r;
    cnt_nxt   = cnt_r;
    grp_step  = '0;

    bo     = body_step(in_byte_r, delim_r, check_end_r);
    hx_ok  = 1'b1;
    hx_d   = 4'd0;
    if (in_byte_r >= CH_0 && in_byte_r <= CH_9) begin
      hx_d = 4'(in_byte_r - CH_0);
    end else if (in_byte_r >= CH_LA && in_byte_r <= CH_LF) begin
      hx_d = 4'(in_byte_r - CH_LA + 8'd10);
    end else if (in_byte_r >= CH_UA && in_byte_r <= CH_UF) begin
      hx_d = 4'(in_byte_r - CH_UA + 8'd10);
    end else begin
      hx_ok = 1'b0;
    end
    is_oct = in_byte_r >= CH_0 && in_byte_r <= CH_7;
    uv     = {acc_r[27:0], hx_d};
    oct_v  = {acc_r[28:0], in_byte_r[2:0]};
    uc     = cnt_r + 4'd1;
    need   = (phase_r == PH_U8) ? 4'd8 : 4'd4;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == delim_r) begin
          phase_nxt = PH_BODY;
        end else begin
          grp_step.n    = 3'd1;
          grp_step.r[0] = mk_err(ERR_NO_OPENER);
        end
      end
      PH_BODY: begin
        phase_nxt     = bo.ph;
        grp_step.n    = {2'b00, bo.vld};
        grp_step.r[0] = bo.r;
      end
      PH_ESC: begin
        phase_nxt     = PH_BODY;
        acc_nxt       = '0;
        cnt_nxt       = '0;
        grp_step.n    = 3'd1;
        grp_step.r[0] = mk_data(in_byte_r);
        case (in_byte_r)
          CH_LA: grp_step.r[0] = mk_data(8'd7);
          CH_LB: grp_step.r[0] = mk_data(8'd8);
          CH_LT: grp_step.r[0] = mk_data(8'd9);
          CH_LV: grp_step.r[0] = mk_data(8'd11);
          CH_LN: grp_step.r[0] = mk_data(8'd10);
          CH_LR: grp_step.r[0] = mk_data(8'd13);
          CH_LF: grp_step.r[0] = mk_data(8'd12);
          CH_LX: begin
            phase_nxt  = PH_HEX;
            grp_step.n = 3'd0;
          end
          CH_LU: begin
            if (unicode_r) begin
              phase_nxt  = PH_U4;
              grp_step.n = 3'd0;
            end
          end
          CH_UU: begin
            if (unicode_r) begin
              phase_nxt  = PH_U8;
              grp_step.n = 3'd0;
            end
          end
          default: begin
            if (is_oct) begin
              acc_nxt    = {29'd0, in_byte_r[2:0]};
              cnt_nxt    = 4'd1;
              phase_nxt  = PH_OCT;
              grp_step.n = 3'd0;
            end
          end
        endcase
      end
      PH_HEX: begin
        if (hx_ok) begin
          acc_nxt = uv;
        end else begin
          acc_nxt       = '0;
          phase_nxt     = bo.ph;
          grp_step.r[0] = mk_data(acc_r[7:0]);
          grp_step.r[1] = bo.r;
          grp_step.n    = bo.vld ? 3'd2 : 3'd1;
        end
      end
      PH_OCT: begin
        if (is_oct && cnt_r < 4'd3) begin
          acc_nxt = oct_v;
          cnt_nxt = uc;
          if (uc >= 4'd3) begin
            acc_nxt       = '0;
            cnt_nxt       = '0;
            phase_nxt     = PH_BODY;
            grp_step.n    = 3'd1;
            grp_step.r[0] = mk_data(oct_v[7:0]);
          end
        end else begin
          acc_nxt       = '0;
          cnt_nxt       = '0;
          phase_nxt     = bo.ph;
          grp_step.r[0] = mk_data(acc_r[7:0]);
          grp_step.r[1] = bo.r;
          grp_step.n    = bo.vld ? 3'd2 : 3'd1;
        end
      end
      PH_U4, PH_U8, PH_LOW4: begin
        if (!hx_ok) begin
          phase_nxt     = PH_IDLE;
          grp_step.n    = 3'd1;
          grp_step.r[0] = mk_err(ERR_UNIVERSAL);
        end else if (uc < need) begin
          acc_nxt = uv;
          cnt_nxt = uc;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (phase_r == PH_U8) begin
            if (uv > CP_MAX) begin
              phase_nxt     = PH_IDLE;
              grp_step.n    = 3'd1;
              grp_step.r[0] = mk_err(ERR_RANGE);
            end else begin
              phase_nxt = PH_BODY;
              grp_step  = utf8(uv[20:0]);
            end
          end else if (phase_r == PH_LOW4) begin
            if (uv >= LO_SURR_MIN && uv <= LO_SURR_MAX) begin
              phase_nxt = PH_BODY;
              grp_step  = utf8(SUPP_BASE + {1'b0, hs_r, uv[9:0]});
            end else begin
              phase_nxt     = PH_IDLE;
              grp_step.n    = 3'd1;
              grp_step.r[0] = mk_err(ERR_SURROGATE);
            end
          end else if (uv >= HI_SURR_MIN && uv <= HI_SURR_MAX) begin
            hs_nxt    = uv[9:0];
            phase_nxt = PH_WANT_BS;
          end else begin
            phase_nxt = PH_BODY;
            grp_step  = utf8(uv[20:0]);
          end
        end
      end
      PH_WANT_BS: begin
        if (in_byte_r == CH_BSLASH) begin
          phase_nxt = PH_WANT_U;
        end else begin
          phase_nxt     = PH_IDLE;
          grp_step.n    = 3'd1;
          grp_step.r[0] = mk_err(ERR_SURROGATE);
        end
      end
      PH_WANT_U: begin
        if (in_byte_r == CH_LU) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_LOW4;
        end else begin
          phase_nxt     = PH_IDLE;
          grp_step.n    = 3'd1;
          grp_step.r[0] = mk_err(ERR_SURROGATE);
        end
      end
      default: begin
        phase_nxt     = PH_IDLE;
        grp_step.n    = 3'd1;
        grp_step.r[0] = mk_err(ERR_NO_OPENER);
      end
    endcase
  end

  `CSE_ASSERT_NEXT(a_err_to_idle, step && grp_step.n != 3'd0 && grp_step.r[grp_step.n[1:0] - 2'd1].kind == KIND_ERROR, phase_r == PH_IDLE, "error result did not return parser to idle")
  `CSE_ASSERT_IMPLY(a_want_u_order, phase_r == PH_WANT_U, $past(phase_r) == PH_WANT_BS || $past(phase_r) == PH_WANT_U, "low surrogate prefix reached out of order")

endmodule

// File: hdl/cse_serial.sv
// ----------------------------------------------------------------------------
// C string escape decoder result queue
// Two-entry queue of result groups, drained one result per request with the
// last flag set on the final result of each group.
// ----------------------------------------------------------------------------
`include "c_string_escape_decoder_assert.svh"

module cse_serial import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      grp,
  output logic      q_ready,
  cse_out_if.source out_chan
);

  grp_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;

  grp_t       head;
  res_t       hd_res;
  logic       push;
  logic       fire;
  logic       is_last;
  logic       pop;

  assign head    = q_r[rp_r];
  assign hd_res  = head.r[idx_r];
  assign push    = grp.n != 3'd0;
  assign q_ready = cnt_r != 2'd2;
  assign is_last = {1'b0, idx_r} == (head.n - 3'd1);
  assign fire    = out_chan.valid && out_chan.ready;
  assign pop     = fire && is_last;

  assign out_chan.valid      = cnt_r != 2'd0;
  assign out_chan.kind       = hd_res.kind;
  assign out_chan.out_byte   = hd_res.data;
  assign out_chan.error_code = hd_res.err;
  assign out_chan.last       = is_last;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (fire) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  `CSE_ASSERT_IMPLY(a_head_group_ok, cnt_r != 2'd0, head.n != 3'd0 && head.n <= 3'd4 && {1'b0, idx_r} < head.n, "queued group empty or index past its end")
  `CSE_ASSERT_IMPLY(a_no_overflow, push, cnt_r != 2'd2, "group pushed into full queue")
  `CSE_ASSERT_NEXT(a_pop_count, pop && !push, cnt_r == $past(cnt_r) - 2'd1, "queue count not reduced on group pop")

endmodule

// File: hdl/c_string_escape_decoder.sv
// A source byte is registered on acceptance and decoded from that register once
// the result queue has room; its results are then queued and offered on out_chan.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_chan is ready; a byte's k results (up to 4, UTF-8 output) leave one at a time.
// Reset: synchronous, active low; clears parser state and result queue, and sets
// delimiter to 34, end checking off and universal escapes on.
// ----------------------------------------------------------------------------
// C string escape decoder
// Decodes a delimited C string literal one byte per request into data bytes,
// a close marker or an error code, with UTF-8 output for universal escapes.
// ----------------------------------------------------------------------------
module c_string_escape_decoder import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cse_in_if.sink    in_chan,
  cse_out_if.source out_chan,
  cse_cfg_if.sink   cfg_chan
);

  grp_t grp;
  logic q_ready;

  cse_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_ready  (q_ready),
    .grp      (grp)
  );

  cse_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp      (grp),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule
